>>> rtl/q2r_pkg.sv
// Package with shared constants for the quaternion to rotation matrix unit.
`timescale 1ns / 1ps
package q2r_pkg;
    localparam int COMPONENT_WIDTH_DEF = 16;
    localparam int NUM_ELEM = 9;
endpackage

>>> rtl/q2r_products.sv
// Product stage: squares, cross products, norm and signed numerators.
`timescale 1ns / 1ps
module q2r_products
    import q2r_pkg::*;
#(
    parameter int CW = COMPONENT_WIDTH_DEF,
    parameter int NW = 2 * CW + 3
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] w,
    input  logic signed [CW-1:0] x,
    input  logic signed [CW-1:0] y,
    input  logic signed [CW-1:0] z,
    output logic                 out_valid,
    output logic                 out_zero,
    output logic [NW-1:0]        norm,
    output logic signed [NW-1:0] num [NUM_ELEM]
);
    localparam int PW = 2 * CW;

    // First register stage: the ten distinct products.
    logic                 v1_reg;
    logic                 z1_reg;
    logic signed [PW-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PW-1:0] xy_reg, zw_reg, xz_reg, yw_reg, yz_reg, xw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            out_valid <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        z1_reg <= (w == '0) && (x == '0) && (y == '0) && (z == '0);
        ww_reg <= PW'(w) * PW'(w);
        xx_reg <= PW'(x) * PW'(x);
        yy_reg <= PW'(y) * PW'(y);
        zz_reg <= PW'(z) * PW'(z);
        xy_reg <= PW'(x) * PW'(y);
        zw_reg <= PW'(z) * PW'(w);
        xz_reg <= PW'(x) * PW'(z);
        yw_reg <= PW'(y) * PW'(w);
        yz_reg <= PW'(y) * PW'(z);
        xw_reg <= PW'(x) * PW'(w);
    end

    function automatic logic signed [NW-1:0] ext(input logic signed [PW-1:0] v);
        ext = NW'(v);
    endfunction

    // Second register stage: sums; off-diagonal sums are doubled.
    always_ff @(posedge clk)
    begin
        out_zero <= z1_reg;
        norm <= NW'(ext(ww_reg) + ext(xx_reg) + ext(yy_reg) + ext(zz_reg));
        num[0] <= ext(xx_reg) - ext(yy_reg) - ext(zz_reg) + ext(ww_reg);
        num[1] <= (ext(xy_reg) - ext(zw_reg)) <<< 1;
        num[2] <= (ext(xz_reg) + ext(yw_reg)) <<< 1;
        num[3] <= (ext(xy_reg) + ext(zw_reg)) <<< 1;
        num[4] <= ext(yy_reg) - ext(xx_reg) - ext(zz_reg) + ext(ww_reg);
        num[5] <= (ext(yz_reg) - ext(xw_reg)) <<< 1;
        num[6] <= (ext(xz_reg) - ext(yw_reg)) <<< 1;
        num[7] <= (ext(yz_reg) + ext(xw_reg)) <<< 1;
        num[8] <= ext(zz_reg) - ext(xx_reg) - ext(yy_reg) + ext(ww_reg);
    end
endmodule

>>> rtl/q2r_divider.sv
// Pipelined restoring divider for the nine elements, one quotient bit per stage.
`timescale 1ns / 1ps
module q2r_divider
    import q2r_pkg::*;
#(
    parameter int CW = COMPONENT_WIDTH_DEF,
    parameter int NW = 2 * CW + 3
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_zero,
    input  logic [NW-1:0]        norm,
    input  logic signed [NW-1:0] num [NUM_ELEM],
    output logic                 out_valid,
    output logic                 out_zero,
    output logic signed [CW-1:0] elem [NUM_ELEM]
);
    localparam int NS = CW + 1;         // quotient bits: integer bit and CW fraction
    localparam int QW = CW + 1;

    logic              v_reg   [NS+1];
    logic              zf_reg  [NS+1];
    logic              neg_reg [NS+1][NUM_ELEM];
    logic [NW-1:0]     den_reg [NS+1];
    logic [NW:0]       rem_reg [NS+1][NUM_ELEM];
    logic [QW-1:0]     q_reg   [NS+1][NUM_ELEM];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= NS; s++)
            begin
                v_reg[s] <= 1'b0;
            end
            out_valid <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s <= NS; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
            out_valid <= v_reg[NS];
        end
    end

    // Stage 0 takes magnitudes; each later stage settles one quotient bit.
    always_ff @(posedge clk)
    begin
        zf_reg[0] <= in_zero;
        den_reg[0] <= norm;
        for (int e = 0; e < NUM_ELEM; e++)
        begin
            neg_reg[0][e] <= num[e][NW-1];
            rem_reg[0][e] <= num[e][NW-1] ? (NW+1)'(-num[e]) : (NW+1)'(num[e]);
            q_reg[0][e] <= '0;
        end
        for (int s = 1; s <= NS; s++)
        begin
            zf_reg[s] <= zf_reg[s-1];
            den_reg[s] <= den_reg[s-1];
            for (int e = 0; e < NUM_ELEM; e++)
            begin
                neg_reg[s][e] <= neg_reg[s-1][e];
                if (rem_reg[s-1][e] >= {1'b0, den_reg[s-1]})
                begin
                    rem_reg[s][e] <= (rem_reg[s-1][e] - {1'b0, den_reg[s-1]}) << 1;
                    q_reg[s][e] <= {q_reg[s-1][e][QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s][e] <= rem_reg[s-1][e] << 1;
                    q_reg[s][e] <= {q_reg[s-1][e][QW-2:0], 1'b0};
                end
            end
        end
    end

    // Final stage: round half away from zero, saturate positive one.
    logic [QW-1:0] mag_q [NUM_ELEM];
    always_comb
    begin
        for (int e = 0; e < NUM_ELEM; e++)
        begin
            mag_q[e] = QW'((q_reg[NS][e] + QW'(1)) >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        out_zero <= zf_reg[NS];
        for (int e = 0; e < NUM_ELEM; e++)
        begin
            if (zf_reg[NS])
            begin
                elem[e] <= '0;
            end
            else if (neg_reg[NS][e])
            begin
                elem[e] <= CW'(-mag_q[e]);
            end
            else if (mag_q[e] > QW'((1 << (CW-1)) - 1))
            begin
                elem[e] <= {1'b0, {(CW-1){1'b1}}};
            end
            else
            begin
                elem[e] <= CW'(mag_q[e]);
            end
        end
    end
endmodule

>>> rtl/quaternion_to_rotation_matrix_unit.sv
// Top level of the quaternion to rotation matrix unit.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------
//  command  | start, busy           | quat_w quat_x quat_y quat_z
//  result   | done (one-cycle strobe)| r00..r22, zero_norm
//
// One quaternion is taken in every cycle; busy is always low.
// The pipeline has two product/sum stages, one magnitude stage, one divider
// stage per quotient bit, and a rounding stage.
// Reset clears only the valid bits. The receiver cannot stall, so results
// appear exactly once, in order.
`timescale 1ns / 1ps
module quaternion_to_rotation_matrix_unit
    import q2r_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [COMPONENT_WIDTH-1:0] quat_w,
    input  logic signed [COMPONENT_WIDTH-1:0] quat_x,
    input  logic signed [COMPONENT_WIDTH-1:0] quat_y,
    input  logic signed [COMPONENT_WIDTH-1:0] quat_z,
    output logic                              done,
    output logic signed [COMPONENT_WIDTH-1:0] r00,
    output logic signed [COMPONENT_WIDTH-1:0] r10,
    output logic signed [COMPONENT_WIDTH-1:0] r20,
    output logic signed [COMPONENT_WIDTH-1:0] r01,
    output logic signed [COMPONENT_WIDTH-1:0] r11,
    output logic signed [COMPONENT_WIDTH-1:0] r21,
    output logic signed [COMPONENT_WIDTH-1:0] r02,
    output logic signed [COMPONENT_WIDTH-1:0] r12,
    output logic signed [COMPONENT_WIDTH-1:0] r22,
    output logic                              zero_norm
);
    localparam int NW = 2 * COMPONENT_WIDTH + 3;

    logic                 p_valid, p_zero;
    logic [NW-1:0]        p_norm;
    logic signed [NW-1:0] p_num [NUM_ELEM];
    logic signed [COMPONENT_WIDTH-1:0] elem [NUM_ELEM];

    assign busy = 1'b0;

    q2r_products #(.CW(COMPONENT_WIDTH), .NW(NW)) u_products (
        .clk(clk), .rst_n(rst_n), .in_valid(start),
        .w(quat_w), .x(quat_x), .y(quat_y), .z(quat_z),
        .out_valid(p_valid), .out_zero(p_zero), .norm(p_norm), .num(p_num)
    );

    q2r_divider #(.CW(COMPONENT_WIDTH), .NW(NW)) u_divider (
        .clk(clk), .rst_n(rst_n), .in_valid(p_valid), .in_zero(p_zero),
        .norm(p_norm), .num(p_num),
        .out_valid(done), .out_zero(zero_norm), .elem(elem)
    );

    assign r00 = elem[0];
    assign r10 = elem[1];
    assign r20 = elem[2];
    assign r01 = elem[3];
    assign r11 = elem[4];
    assign r21 = elem[5];
    assign r02 = elem[6];
    assign r12 = elem[7];
    assign r22 = elem[8];
endmodule

>>> tb/quaternion_to_rotation_matrix_unit_tb.sv
// Self-checking testbench for the quaternion to rotation matrix unit.
`timescale 1ns / 1ps
module quaternion_to_rotation_matrix_unit_tb;
    import q2r_pkg::*;

    localparam int CW = COMPONENT_WIDTH_DEF;
    localparam int LATENCY = CW + 5;
    localparam int STALL_LIMIT = 2000;

    typedef logic signed [CW-1:0] comp_t;
    typedef struct packed {
        comp_t w;
        comp_t x;
        comp_t y;
        comp_t z;
    } quat_t;
    typedef struct packed {
        comp_t [NUM_ELEM-1:0] elem;
        logic zero_norm;
    } matrix_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    comp_t quat_w, quat_x, quat_y, quat_z;
    logic done;
    comp_t r00, r10, r20, r01, r11, r21, r02, r12, r22;
    logic zero_norm;

    quat_t pending_quats[$];
    matrix_t expected_matrices[$];
    int error_count;
    int idle_cycles;
    bit stimulus_done;
    bit steady_phase;

    quaternion_to_rotation_matrix_unit u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .done(done), .r00(r00), .r10(r10), .r20(r20), .r01(r01), .r11(r11),
        .r21(r21), .r02(r02), .r12(r12), .r22(r22), .zero_norm(zero_norm)
    );

    // Rounded, saturated ratio scale*num/norm as a fixed-point code.
    function automatic comp_t scaled_ratio(longint num, bit dbl, longint norm);
        longint mag_num;
        longint q;
        longint m;
        bit neg;
        begin
            neg = num < 0;
            mag_num = neg ? -num : num;
            if (dbl)
                mag_num = mag_num * 2;
            q = (mag_num << CW) / norm;
            m = (q + 1) >>> 1;
            if (neg)
                return comp_t'(-m);
            if (m > (2 ** (CW - 1)) - 1)
                m = (2 ** (CW - 1)) - 1;
            return comp_t'(m);
        end
    endfunction

    function automatic matrix_t rotation_of(quat_t q);
        matrix_t r;
        longint w, x, y, z, n;
        begin
            w = q.w;
            x = q.x;
            y = q.y;
            z = q.z;
            r = '0;
            if (w == 0 && x == 0 && y == 0 && z == 0) begin
                r.zero_norm = 1'b1;
                return r;
            end
            n = w*w + x*x + y*y + z*z;
            r.elem[0] = scaled_ratio(x*x - y*y - z*z + w*w, 1'b0, n);
            r.elem[1] = scaled_ratio(x*y - z*w, 1'b1, n);
            r.elem[2] = scaled_ratio(x*z + y*w, 1'b1, n);
            r.elem[3] = scaled_ratio(x*y + z*w, 1'b1, n);
            r.elem[4] = scaled_ratio(-x*x + y*y - z*z + w*w, 1'b0, n);
            r.elem[5] = scaled_ratio(y*z - x*w, 1'b1, n);
            r.elem[6] = scaled_ratio(x*z - y*w, 1'b1, n);
            r.elem[7] = scaled_ratio(y*z + x*w, 1'b1, n);
            r.elem[8] = scaled_ratio(-x*x - y*y + z*z + w*w, 1'b0, n);
            return r;
        end
    endfunction

    function automatic comp_t random_comp();
        int sel;
        begin
            sel = $urandom_range(0, 9);
            case (sel)
                0: return comp_t'(-(2 ** (CW - 1)));
                1: return comp_t'((2 ** (CW - 1)) - 1);
                2: return '0;
                3: return comp_t'($urandom_range(0, 15)) - comp_t'(8);
                default: return comp_t'($urandom);
            endcase
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        quat_t q;
        comp_t ext[4];
        rst_n = 1'b0;
        start = 1'b0;
        quat_w = '0;
        quat_x = '0;
        quat_y = '0;
        quat_z = '0;
        error_count = 0;
        stimulus_done = 1'b0;
        steady_phase = 1'b0;
        ext[0] = comp_t'(-(2 ** (CW - 1)));
        ext[1] = comp_t'((2 ** (CW - 1)) - 1);
        ext[2] = '0;
        ext[3] = comp_t'(1);
        // Directed part: zero quaternion, single axes and the extremes.
        pending_quats.push_back('{'0, '0, '0, '0});
        for (int i = 0; i < 4; i++)
            pending_quats.push_back('{ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4],
                                      ext[(i + 3) % 4]});
        pending_quats.push_back('{ext[0], ext[0], ext[0], ext[0]});
        pending_quats.push_back('{ext[1], ext[1], ext[1], ext[1]});
        pending_quats.push_back('{ext[0], ext[1], ext[0], ext[1]});
        pending_quats.push_back('{'0, ext[0], '0, '0});
        pending_quats.push_back('{'0, '0, ext[1], '0});
        pending_quats.push_back('{'0, '0, '0, ext[0]});
        pending_quats.push_back('{ext[1], '0, '0, '0});
        pending_quats.push_back('{'0, '0, '0, comp_t'(1)});
        pending_quats.push_back('{comp_t'(-1), '0, '0, '0});
        pending_quats.push_back('{comp_t'(1), comp_t'(1), comp_t'(1), comp_t'(1)});
        pending_quats.push_back('{comp_t'(16'h5a82), comp_t'(16'h5a82), '0, '0});
        pending_quats.push_back('{comp_t'(16'h5a82), '0, comp_t'(16'ha57e), '0});
        for (int i = 0; i < 1450; i++) begin
            q.w = random_comp();
            q.x = random_comp();
            q.y = random_comp();
            q.z = random_comp();
            pending_quats.push_back(q);
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (pending_quats.size() == 0 && expected_matrices.size() == 0);
        repeat (LATENCY + 5) @(posedge clk);
        stimulus_done = 1'b1;
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Driver: one transfer per accepted start; roughly 37 percent idle outside the
    // stretch with no idling in the middle of the run.
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (pending_quats.size() > 0 && !(start && busy)) begin
                if (pending_quats.size() < 900 && pending_quats.size() > 600)
                    steady_phase = 1'b1;
                else
                    steady_phase = 1'b0;
                if (!steady_phase && $urandom_range(0, 99) < 37) begin
                    start <= 1'b0;
                end else begin
                    start <= 1'b1;
                    quat_w <= pending_quats[0].w;
                    quat_x <= pending_quats[0].x;
                    quat_y <= pending_quats[0].y;
                    quat_z <= pending_quats[0].z;
                end
            end else if (pending_quats.size() == 0) begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: sample transfers and results at the rising edge.
    always @(posedge clk)
    begin
        matrix_t got;
        matrix_t want;
        if (rst_n) begin
            if (start && !busy && pending_quats.size() > 0) begin
                expected_matrices.push_back(rotation_of(pending_quats.pop_front()));
                idle_cycles <= 0;
            end else if (done) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (done) begin
                got.elem[0] = r00;
                got.elem[1] = r10;
                got.elem[2] = r20;
                got.elem[3] = r01;
                got.elem[4] = r11;
                got.elem[5] = r21;
                got.elem[6] = r02;
                got.elem[7] = r12;
                got.elem[8] = r22;
                got.zero_norm = zero_norm;
                if (expected_matrices.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, got);
                    error_count++;
                end else begin
                    want = expected_matrices.pop_front();
                    for (int i = 0; i < NUM_ELEM; i++)
                        if (got.elem[i] !== want.elem[i]) begin
                            $display("%0t: element %0d mismatch, expected %0d, actual %0d",
                                     $time, i, want.elem[i], got.elem[i]);
                            error_count++;
                        end
                    if (got.zero_norm !== want.zero_norm) begin
                        $display("%0t: zero_norm mismatch, expected %b, actual %b",
                                 $time, want.zero_norm, got.zero_norm);
                        error_count++;
                    end
                end
            end
            if (idle_cycles >= STALL_LIMIT && !stimulus_done) begin
                $display("%0t: watchdog expired", $time);
                $display("TEST FAILED");
                $finish;
            end
        end else begin
            idle_cycles <= 0;
        end
    end
endmodule

>>> quaternion_to_rotation_matrix_unit.f
rtl/q2r_pkg.sv
rtl/q2r_products.sv
rtl/q2r_divider.sv
rtl/quaternion_to_rotation_matrix_unit.sv
tb/quaternion_to_rotation_matrix_unit_tb.sv
